// ===== sv/column_post_patch_compositor_defines.svh =====
// Assertion macros used by the compositor top level.
`ifndef COLUMN_POST_PATCH_COMPOSITOR_DEFINES_SVH
`define COLUMN_POST_PATCH_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cpc_pkg.sv =====
// Shared types and constants of the column post compositor.
package cpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_HEIGHT = 3'd4;

  localparam logic [7:0] END_MARK = 8'hFF;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [5:0] {
    PH_END  = 6'b000001,
    PH_TOP  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_PAD1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_PAD2 = 6'b100000
  } cpc_phase_t;

  typedef enum logic {
    OP_PAL   = 1'b0,
    OP_TEXEL = 1'b1
  } cpc_op_t;

  typedef struct packed {
    cpc_op_t     op;
    logic [7:0]  idx;
    logic [23:0] rgb;
    logic [9:0]  x;
    logic [9:0]  y;
  } cpc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cpc_q_status_t;

endpackage

// ===== sv/cpc_front.sv =====
// Front end: config registers, post parser, placement and clipping.
module cpc_front #(
  parameter int MAX_DIM = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  cpc_pkg::cpc_q_status_t          q_stat,
  output logic                            q_push,
  output cpc_pkg::cpc_entry_t             q_entry
);

  localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

  logic [10:0] tex_w_r, tex_h_r;
  logic [15:0] origin_x_r, origin_y_r;
  logic [9:0]  patch_h_r;

  cpc_pkg::cpc_phase_t phase_r, phase_nxt, phase_eff;
  logic [9:0]  col_r, col_nxt, col_eff;
  logic [7:0]  top_r, top_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  rip_r, rip_nxt;

  logic        in_mode, in_start;
  logic [9:0]  in_column;
  logic [7:0]  in_byte;
  logic [23:0] in_rgb;
  logic        accept;
  logic [8:0]  row;
  logic [16:0] x_sum, y_sum, bound_x, bound_y;
  logic        hit;

  assign in_mode   = in_tuser[0];
  assign in_start  = in_tuser[1];
  assign in_column = in_tdata[9:0];
  assign in_byte   = in_tdata[17:10];
  assign in_rgb    = in_tdata[41:18];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r    <= 11'd64;
      tex_h_r    <= 11'd64;
      origin_x_r <= 16'd0;
      origin_y_r <= 16'd0;
      patch_h_r  <= 10'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpc_pkg::CFG_TEX_WIDTH:    tex_w_r    <= cfg_data[10:0];
        cpc_pkg::CFG_TEX_HEIGHT:   tex_h_r    <= cfg_data[10:0];
        cpc_pkg::CFG_ORIGIN_X:     origin_x_r <= cfg_data;
        cpc_pkg::CFG_ORIGIN_Y:     origin_y_r <= cfg_data;
        cpc_pkg::CFG_PATCH_HEIGHT: patch_h_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Placement: signed origin plus column and row, clipped to the bounds.
  assign phase_eff = in_start ? cpc_pkg::PH_TOP : phase_r;
  assign col_eff   = in_start ? in_column : col_r;
  assign row       = {1'b0, top_r} + {1'b0, rip_r};
  assign x_sum     = {origin_x_r[15], origin_x_r} + {7'd0, col_eff};
  assign y_sum     = {origin_y_r[15], origin_y_r} + {8'd0, row};
  assign bound_x   = ({6'd0, tex_w_r} > MAX_DIM_V) ? MAX_DIM_V : {6'd0, tex_w_r};
  assign bound_y   = ({6'd0, tex_h_r} > MAX_DIM_V) ? MAX_DIM_V : {6'd0, tex_h_r};
  assign hit       = ({1'b0, row} < patch_h_r) && !x_sum[16] && (x_sum < bound_x)
                     && !y_sum[16] && (y_sum < bound_y);

  always_comb begin
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    left_nxt      = left_r;
    rip_nxt       = rip_r;
    q_push        = 1'b0;
    q_entry.op    = cpc_pkg::OP_PAL;
    q_entry.idx   = in_byte;
    q_entry.rgb   = in_rgb;
    q_entry.x     = x_sum[9:0];
    q_entry.y     = y_sum[9:0];
    if (accept) begin
      if (!in_mode) begin
        q_push = 1'b1;
      end else begin
        col_nxt = col_eff;
        unique case (phase_eff)
          cpc_pkg::PH_END: begin
            phase_nxt = cpc_pkg::PH_END;
          end
          cpc_pkg::PH_TOP: begin
            if (in_byte == cpc_pkg::END_MARK) begin
              phase_nxt = cpc_pkg::PH_END;
            end else begin
              top_nxt   = in_byte;
              phase_nxt = cpc_pkg::PH_LEN;
            end
          end
          cpc_pkg::PH_LEN: begin
            left_nxt  = in_byte;
            rip_nxt   = 8'd0;
            phase_nxt = cpc_pkg::PH_PAD1;
          end
          cpc_pkg::PH_PAD1: begin
            phase_nxt = (left_r == 8'd0) ? cpc_pkg::PH_PAD2 : cpc_pkg::PH_DATA;
          end
          cpc_pkg::PH_DATA: begin
            q_push     = hit;
            q_entry.op = cpc_pkg::OP_TEXEL;
            rip_nxt    = rip_r + 8'd1;
            left_nxt   = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = cpc_pkg::PH_PAD2;
            end
          end
          cpc_pkg::PH_PAD2: begin
            phase_nxt = cpc_pkg::PH_TOP;
          end
          default: begin
            phase_nxt = cpc_pkg::PH_END;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cpc_pkg::PH_END;
      col_r   <= 10'd0;
      top_r   <= 8'd0;
      left_r  <= 8'd0;
      rip_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      top_r   <= top_nxt;
      left_r  <= left_nxt;
      rip_r   <= rip_nxt;
    end
  end

endmodule

// ===== sv/cpc_fifo.sv =====
// Short queue of palette writes and texel requests between front and back.
module cpc_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cpc_pkg::cpc_entry_t    push_entry,
  input  logic                   pop,
  output cpc_pkg::cpc_entry_t    head,
  output cpc_pkg::cpc_q_status_t stat
);

  cpc_pkg::cpc_entry_t slot_r [cpc_pkg::Q_DEPTH];
  logic [cpc_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [cpc_pkg::Q_AW:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (cpc_pkg::Q_AW+1)'(cpc_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/cpc_back.sv =====
// Back end: palette memory and the texel output register.
module cpc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cpc_pkg::cpc_entry_t    head,
  input  cpc_pkg::cpc_q_status_t q_stat,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata
);

  logic [23:0] pal_mem [256];
  logic [23:0] rgb_r;
  logic [9:0]  x_r, y_r;
  logic        valid_r, valid_nxt;
  logic        take_texel;

  // A palette write never waits; a texel waits for a free output register.
  assign q_pop = !q_stat.empty &&
                 (head.op == cpc_pkg::OP_PAL || !valid_r || out_tready);
  assign take_texel = q_pop && (head.op == cpc_pkg::OP_TEXEL);

  always_comb begin
    valid_nxt = valid_r;
    if (take_texel) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head.op == cpc_pkg::OP_PAL) begin
      pal_mem[head.idx] <= head.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (take_texel) begin
      rgb_r <= pal_mem[head.idx];
      x_r   <= head.x;
      y_r   <= head.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, rgb_r[7:0], rgb_r[15:8], rgb_r[23:16], y_r, x_r};

endmodule

// ===== sv/column_post_patch_compositor.sv =====
// Top level of the column post compositor: front parser, queue and palette back end.
`include "column_post_patch_compositor_defines.svh"
// Parses column bytes in posts form and emits one clipped texel write per visible colour
// byte, coloured from a 256-entry palette that mode 0 words load. One input word is taken
// every cycle unless the queue is full, which alone stalls the input; the front parser
// handles each word in its accept cycle, and the back end pops palette loads and texels,
// reading the palette memory into the output register. A texel is held in a queue slot,
// then in the output register. A four-entry queue between the two absorbs output
// stalls. No clearing pass runs after reset; palette entries are defined once loaded.
module column_post_patch_compositor #(
  parameter int MAX_DIM = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [9:0] column, [17:10] data_byte, [41:18] palette_rgb, [47:42] zero
  input  logic [47:0]                     in_tdata,
  // [0] mode, [1] column_start
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [9:0] texel_x, [19:10] texel_y, [27:20] red, [35:28] green, [43:36] blue
  output logic [47:0]                     out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cpc_pkg::cpc_q_status_t q_stat;
  cpc_pkg::cpc_entry_t    q_entry, q_head;
  logic                   q_push, q_pop;

  cpc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  cpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  cpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `CPC_ASSERT_NOW(a_no_overflow, q_stat.full, !q_push, "queue push while full")
  `CPC_ASSERT_NOW(a_no_underflow, q_stat.empty, !q_pop, "queue pop while empty")
  `CPC_ASSERT_NEXT(a_texel_from_queue, !q_pop && !out_tvalid, !out_tvalid,
                   "output word appeared without a queue pop")

endmodule

// ===== test/tb_column_post_patch_compositor.sv =====
// Self-checking testbench of the column post compositor with a texel scoreboard.
typedef struct {
  logic [9:0] x;
  logic [9:0] y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} texel_t;

class texel_predictor;
  localparam int DIM_LIMIT = 1024;

  logic [10:0]        tex_w;
  logic [10:0]        tex_h;
  logic signed [15:0] org_x;
  logic signed [15:0] org_y;
  logic [9:0]         patch_rows;

  cpc_pkg::cpc_phase_t phase;
  logic [9:0]  cur_col;
  logic [7:0]  post_top;
  logic [7:0]  left;
  logic [7:0]  row;
  logic [23:0] palette [256];

  texel_t pending [$];
  int     fails;
  int     texels_seen;

  function new();
    tex_w      = 11'd64;
    tex_h      = 11'd64;
    org_x      = '0;
    org_y      = '0;
    patch_rows = 10'd128;
    phase      = cpc_pkg::PH_END;
    cur_col    = '0;
    post_top   = '0;
    left       = '0;
    row        = '0;
    foreach (palette[i]) palette[i] = '0;
    fails       = 0;
    texels_seen = 0;
  endfunction

  function void flag(string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endfunction

  function void set_reg(logic [cpc_pkg::CFG_IDX_W-1:0] idx,
                        logic [cpc_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      cpc_pkg::CFG_TEX_WIDTH:    tex_w = v[10:0];
      cpc_pkg::CFG_TEX_HEIGHT:   tex_h = v[10:0];
      cpc_pkg::CFG_ORIGIN_X:     org_x = v;
      cpc_pkg::CFG_ORIGIN_Y:     org_y = v;
      cpc_pkg::CFG_PATCH_HEIGHT: patch_rows = v[9:0];
      default: ;
    endcase
  endfunction

  // Place one colour byte; push a texel if its row is inside the patch height and it lands inside the texture.
  function void place(logic [7:0] idx);
    int     r;
    int     x;
    int     y;
    int     bx;
    int     by;
    texel_t t;
    r = int'(post_top) + int'(row);
    if (r >= int'(patch_rows)) return;
    x  = int'(org_x) + int'(cur_col);
    y  = int'(org_y) + r;
    bx = (int'(tex_w) > DIM_LIMIT) ? DIM_LIMIT : int'(tex_w);
    by = (int'(tex_h) > DIM_LIMIT) ? DIM_LIMIT : int'(tex_h);
    if (x < 0 || y < 0 || x >= bx || y >= by) return;
    t.x     = x[9:0];
    t.y     = y[9:0];
    t.red   = palette[idx][23:16];
    t.green = palette[idx][15:8];
    t.blue  = palette[idx][7:0];
    pending.push_back(t);
  endfunction

  // Advance the parser by one accepted word; returns 0 when the word is ignored.
  function bit absorb_word(cpc_pkg::cpc_op_t op, bit start, logic [9:0] col,
                           logic [7:0] b, logic [23:0] rgb);
    if (op == cpc_pkg::OP_PAL) begin
      palette[b] = rgb;
      return 1'b1;
    end
    if (start) begin
      cur_col = col;
      phase   = cpc_pkg::PH_TOP;
    end
    case (phase)
      cpc_pkg::PH_END: return 1'b0;
      cpc_pkg::PH_TOP: begin
        if (b == cpc_pkg::END_MARK) phase = cpc_pkg::PH_END;
        else begin
          post_top = b;
          phase    = cpc_pkg::PH_LEN;
        end
      end
      cpc_pkg::PH_LEN: begin
        left  = b;
        row   = '0;
        phase = cpc_pkg::PH_PAD1;
      end
      cpc_pkg::PH_PAD1: phase = (left == 8'd0) ? cpc_pkg::PH_PAD2 : cpc_pkg::PH_DATA;
      cpc_pkg::PH_DATA: begin
        place(b);
        row  = row + 8'd1;
        left = left - 8'd1;
        if (left == 8'd0) phase = cpc_pkg::PH_PAD2;
      end
      cpc_pkg::PH_PAD2: phase = cpc_pkg::PH_TOP;
      default: phase = cpc_pkg::PH_END;
    endcase
    return 1'b1;
  endfunction

  function void compare_texel(logic [47:0] d);
    texel_t e;
    if (pending.size() == 0) begin
      flag($sformatf("unexpected texel x=%0d y=%0d", d[9:0], d[19:10]));
      return;
    end
    e = pending.pop_front();
    texels_seen++;
    if (d[9:0] !== e.x || d[19:10] !== e.y || d[27:20] !== e.red ||
        d[35:28] !== e.green || d[43:36] !== e.blue)
      flag($sformatf("texel exp x=%0d y=%0d rgb=%02h%02h%02h got x=%0d y=%0d rgb=%02h%02h%02h",
                     e.x, e.y, e.red, e.green, e.blue,
                     d[9:0], d[19:10], d[27:20], d[35:28], d[43:36]));
  endfunction
endclass

module tb_column_post_patch_compositor;
  localparam int STALL_LIMIT = 2000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [47:0]                    in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [47:0]                    out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data;

  texel_predictor model;
  int in_idle_pct;
  int out_idle_pct;
  int rx_hold;
  int words_counted;
  int settings_used;

  column_post_patch_compositor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off while rx_hold runs down.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.compare_texel(out_tdata);
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(cpc_pkg::cpc_op_t op, bit start, logic [9:0] col,
                           logic [7:0] b, logic [23:0] rgb);
    // hold valid low for a run of cycles, each idle with the sender's idle odds
    if ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= {start, op};
    in_tdata  <= {6'd0, rgb, b, col};
    do @(posedge clk); while (!in_tready);
    if (model.absorb_word(op, start, col, b, rgb)) words_counted++;
  endtask

  task automatic send_byte(bit start, logic [9:0] col, logic [7:0] b);
    send_word(cpc_pkg::OP_TEXEL, start, col, b, 24'($urandom));
  endtask

  task automatic send_palette(logic [7:0] idx);
    send_word(cpc_pkg::OP_PAL, 1'($urandom), 10'($urandom), idx, 24'($urandom));
  endtask

  // Drop valid, wait for every texel, then let queued palette loads retire.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [cpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [cpc_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int k);
    logic [15:0] w;
    logic [15:0] h;
    int          ox;
    int          oy;
    logic [15:0] ph;
    case (k)
      0: begin w = 64;   h = 64;   ox = 0;      oy = 0;      ph = 128;  end
      1: begin w = 1024; h = 1024; ox = 0;      oy = 0;      ph = 1023; end
      2: begin w = 1;    h = 1;    ox = 0;      oy = 0;      ph = 1;    end
      3: begin w = 1024; h = 1024; ox = -32768; oy = -32768; ph = 1023; end
      4: begin w = 2047; h = 2047; ox = 1000;   oy = 990;    ph = 1023; end
      5: begin w = 0;    h = 0;    ox = 0;      oy = 0;      ph = 1023; end
      6: begin w = 40;   h = 300;  ox = -5;     oy = -100;   ph = 0;    end
      7: begin w = 1024; h = 1024; ox = 32767;  oy = 32767;  ph = 512;  end
      8: begin w = 1024; h = 1024; ox = -3;     oy = -20;    ph = 200;  end
      default: begin
        w  = ($urandom_range(99) < 60) ? 16'($urandom_range(32, 128)) :
                                         16'($urandom_range(2047));
        h  = ($urandom_range(99) < 60) ? 16'($urandom_range(32, 128)) :
                                         16'($urandom_range(2047));
        // upper data bits lie outside the register and must be dropped
        w[15:11] = 5'($urandom);
        h[15:11] = 5'($urandom);
        ox = ($urandom_range(99) < 70) ? int'($urandom_range(80)) - 40 :
                                         int'($urandom_range(65535)) - 32768;
        oy = int'($urandom_range(80)) - 40;
        ph = 16'($urandom_range(1023));
      end
    endcase
    wait_idle();
    write_reg(cpc_pkg::CFG_TEX_WIDTH, w);
    write_reg(cpc_pkg::CFG_TEX_HEIGHT, h);
    write_reg(cpc_pkg::CFG_ORIGIN_X, 16'(ox));
    write_reg(cpc_pkg::CFG_ORIGIN_Y, 16'(oy));
    write_reg(cpc_pkg::CFG_PATCH_HEIGHT, ph);
    settings_used++;
  endtask

  // One column of posts; a broken column may stop mid-post and trail stray bytes.
  task automatic send_column(bit clean, int min_len);
    logic [9:0] col;
    int         posts;
    int         top;
    int         len;
    int         r;
    col   = ($urandom_range(99) < 70) ? 10'($urandom_range(63)) : 10'($urandom_range(1023));
    posts = $urandom_range(1, 4);
    for (int p = 0; p < posts; p++) begin
      top = ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(254);
      r   = $urandom_range(99);
      if (r < 90)      len = $urandom_range(6);
      else if (r < 98) len = $urandom_range(7, 40);
      else             len = $urandom_range(41, 255);
      if (len < min_len) len = min_len;
      send_byte(p == 0, col, 8'(top));
      send_byte(1'b0, 10'($urandom), 8'(len));
      send_byte(1'b0, 10'($urandom), 8'($urandom));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 5) send_palette(8'($urandom));
        send_byte(1'b0, 10'($urandom), 8'($urandom));
        if (!clean && $urandom_range(99) < 4) return;
      end
      send_byte(1'b0, 10'($urandom), 8'($urandom));
    end
    send_byte(1'b0, 10'($urandom), cpc_pkg::END_MARK);
    if (!clean) begin
      repeat ($urandom_range(1, 3)) send_byte(1'b0, 10'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_block(int n);
    int first;
    int r;
    first = words_counted;
    while (words_counted - first < n) begin
      r = $urandom_range(99);
      if (r < 80)      send_column(1'b1, 0);
      else if (r < 95) send_column(1'b0, 0);
      else send_word(cpc_pkg::cpc_op_t'($urandom_range(1)), 1'($urandom),
                     10'($urandom), 8'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    model         = new();
    in_idle_pct   = 8;
    out_idle_pct  = 77;
    rx_hold       = 0;
    words_counted = 0;
    settings_used = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = cpc_pkg::CFG_TEX_WIDTH;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load every palette entry so no texel reads an unwritten one
    for (int i = 0; i < 256; i++) send_palette(8'(i));

    // Directed part under the reset register values.
    send_byte(1'b1, 10'd5, 8'd2);
    send_byte(1'b0, 10'd1023, 8'd3);
    send_byte(1'b0, 10'd0, 8'hFF);
    send_byte(1'b0, 10'd0, 8'h00);
    send_byte(1'b0, 10'd0, 8'hFF);
    send_byte(1'b0, 10'd0, 8'h5A);
    send_byte(1'b0, 10'd0, 8'h00);
    // empty post
    send_byte(1'b0, 10'd0, 8'd0);
    send_byte(1'b0, 10'd0, 8'd0);
    send_byte(1'b0, 10'd0, 8'd0);
    send_byte(1'b0, 10'd0, 8'd0);
    // post crossing the bottom edge of the texture
    send_byte(1'b0, 10'd0, 8'd62);
    send_byte(1'b0, 10'd0, 8'd3);
    send_byte(1'b0, 10'd0, 8'd0);
    send_byte(1'b0, 10'd0, 8'h01);
    send_byte(1'b0, 10'd0, 8'h02);
    send_byte(1'b0, 10'd0, 8'h03);
    // new column aborts a post, then an immediate end mark
    send_byte(1'b1, 10'd63, 8'd0);
    send_byte(1'b0, 10'd0, 8'd2);
    send_byte(1'b0, 10'd0, 8'd0);
    send_byte(1'b0, 10'd0, 8'h11);
    send_byte(1'b1, 10'd1023, cpc_pkg::END_MARK);
    // stray byte after the end, and a load with start and column set
    send_byte(1'b0, 10'd7, 8'd9);
    send_word(cpc_pkg::OP_PAL, 1'b1, 10'd1023, 8'hFF, 24'hFFFFFF);

    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin in_idle_pct = 8;  out_idle_pct = 77; end
        1: begin in_idle_pct = 77; out_idle_pct = 8;  end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        apply_setting(r * 4 + s + 1);
        run_block(12);
      end
    end

    // Hold the receiver off while long posts keep coming, so the queue fills.
    apply_setting(1);
    @(posedge clk);
    rx_hold = 300;
    send_column(1'b1, 40);
    wait_idle();

    if (model.pending.size() != 0)
      model.flag($sformatf("%0d texels never arrived", model.pending.size()));
    $display("covered %0d words and %0d texels over %0d register settings",
             words_counted, model.texels_seen, settings_used);
    $display("with palette reloads, broken columns, clipping and a long output stall");
    if (model.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", model.fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/cpc_pkg.sv
sv/cpc_front.sv
sv/cpc_fifo.sv
sv/cpc_back.sv
sv/column_post_patch_compositor.sv
test/tb_column_post_patch_compositor.sv
